/* design/cxpd_pkg.sv */
// Shared constants and types for the circular cross-correlation peak delay block.
// Holds field widths, parameter defaults and configuration register indexes.
// No dependencies.
package cxpd_pkg;

    localparam int MAX_FRAMES_DEF  = 1024;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int LEN_W = 11;
    localparam int MAG_W = 41;
    localparam int LAG_W = 10;
    localparam int CFG_INDEX_W = 1;

    localparam logic [LEN_W-1:0] FRAME_LENGTH_RST = LEN_W'(1024);

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FRAME_LENGTH      = 1'b0,
        CFG_QUALITY_THRESHOLD = 1'b1
    } cfg_reg_t;

endpackage

/* design/circular_xcorr_peak_delay.sv */
// Top level of the circular cross-correlation peak delay estimator.
// Depends on cxpd_pkg for widths, defaults and register indexes.
//
//  Port group   Direction  Handshake             Contents
//  in           receive    in_valid / in_stall   ref_sample, mic_sample
//  out          send       out_valid / out_stall lag_at_peak, peak_magnitude, accepted,
//                                                delay_samples
//  cfg          receive    cfg_we                cfg_index, cfg_data
//
// Each input transaction stores one sample pair. The transaction that
// fills a frame of N pairs starts N*N multiply-accumulate steps on the one shared unit,
// then a pipeline drain; in_stall stays high throughout both.
// The frame-filling transaction is also held off while an earlier result waits on out.
// Reset clears control, tag, accumulator and peak registers; other storage has no reset.
// A result stays on out until out_stall is low; a new frame loads meanwhile up to its last pair.
module circular_xcorr_peak_delay #(
    parameter int MAX_FRAMES  = cxpd_pkg::MAX_FRAMES_DEF,
    parameter int SAMPLE_BITS = cxpd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [SAMPLE_BITS-1:0]       ref_sample,
    input  logic signed [SAMPLE_BITS-1:0]       mic_sample,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [cxpd_pkg::LAG_W-1:0]          lag_at_peak,
    output logic [cxpd_pkg::MAG_W-1:0]          peak_magnitude,
    output logic                                accepted,
    output logic [cxpd_pkg::LAG_W-1:0]          delay_samples,
    input  logic                                cfg_we,
    input  logic [cxpd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [cxpd_pkg::MAG_W-1:0]          cfg_data
);

    localparam int ADDR_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
    localparam int CMP_W  = (CNT_W > cxpd_pkg::LEN_W) ? CNT_W : cxpd_pkg::LEN_W;
    localparam int PROD_W = 2 * SAMPLE_BITS;
    localparam int ACC_W  = PROD_W + ADDR_W;
    localparam int WIDE_W = ((ACC_W > cxpd_pkg::MAG_W) ? ACC_W : cxpd_pkg::MAG_W) + 1;
    localparam int MAG_W  = cxpd_pkg::MAG_W;
    localparam int LAG_W  = cxpd_pkg::LAG_W;

    typedef enum logic [2:0] {
        ST_LOAD  = 3'b001,
        ST_CORR  = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

    typedef struct packed {
        logic              vld;
        logic              first;
        logic              last;
        logic              fin;
        logic [ADDR_W-1:0] lag;
    } tag_t;

    logic signed [SAMPLE_BITS-1:0] ref_mem [MAX_FRAMES];
    logic signed [SAMPLE_BITS-1:0] mic_mem [MAX_FRAMES];

    state_t state_reg, state_next;

    logic [cxpd_pkg::LEN_W-1:0] frame_length_reg;
    logic [MAG_W-1:0]           threshold_reg;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [ADDR_W-1:0] j_reg, j_next;
    logic [ADDR_W-1:0] k_reg, k_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [ADDR_W-1:0] nm1_reg, nm1_next;

    logic [CMP_W-1:0]  fl_ext;
    logic [CMP_W-1:0]  n_val;
    logic [ADDR_W-1:0] wr_addr;
    logic [CNT_W-1:0]  count_after;
    logic              frame_done;
    logic              in_fire;
    logic              issue;
    tag_t              issue_tag;

    logic signed [SAMPLE_BITS-1:0] rd_ref_reg;
    logic signed [SAMPLE_BITS-1:0] rd_mic_reg;
    tag_t                          s1_reg;
    logic signed [PROD_W-1:0]      prod_reg;
    tag_t                          s2_reg;
    logic signed [ACC_W-1:0]       acc_reg;
    tag_t                          s3_reg;
    logic [MAG_W-1:0]              mag_reg;
    tag_t                          s4_reg;
    logic                          s5_done_reg;

    logic signed [WIDE_W-1:0] acc_wide;
    logic [WIDE_W-1:0]        abs_wide;
    logic [MAG_W-1:0]         mag_sat;

    logic [ADDR_W-1:0] best_lag_reg;
    logic [MAG_W-1:0]  best_mag_reg;

    logic              out_valid_reg;
    logic [LAG_W-1:0]  lag_out_reg;
    logic [MAG_W-1:0]  mag_out_reg;
    logic              acc_out_reg;
    logic [LAG_W-1:0]  delay_out_reg;

    always_comb
    begin
        fl_ext = CMP_W'(frame_length_reg);
        if (fl_ext < CMP_W'(2))
        begin
            n_val = CMP_W'(2);
        end
        else if (fl_ext > CMP_W'(MAX_FRAMES))
        begin
            n_val = CMP_W'(MAX_FRAMES);
        end
        else
        begin
            n_val = fl_ext;
        end
    end

    assign wr_addr     = (count_reg >= CNT_W'(MAX_FRAMES)) ? '0 : count_reg[ADDR_W-1:0];
    assign count_after = CNT_W'(wr_addr) + CNT_W'(1);
    assign frame_done  = CMP_W'(count_after) >= n_val;

    assign in_stall = (state_reg != ST_LOAD) || (out_valid_reg && frame_done);
    assign in_fire  = in_valid && !in_stall;
    assign issue    = (state_reg == ST_CORR);

    always_comb
    begin
        issue_tag.vld   = issue;
        issue_tag.first = (j_reg == '0);
        issue_tag.last  = (j_reg == nm1_reg);
        issue_tag.fin   = (k_reg == nm1_reg);
        issue_tag.lag   = k_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        idx_next   = idx_reg;
        nm1_next   = nm1_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_fire)
                begin
                    if (frame_done)
                    begin
                        count_next = '0;
                        j_next     = '0;
                        k_next     = '0;
                        idx_next   = '0;
                        nm1_next   = ADDR_W'(n_val - CMP_W'(1));
                        state_next = ST_CORR;
                    end
                    else
                    begin
                        count_next = count_after;
                    end
                end
            end
            ST_CORR:
            begin
                if (j_reg == nm1_reg)
                begin
                    j_next = '0;
                    if (k_reg == nm1_reg)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        k_next   = k_reg + ADDR_W'(1);
                        idx_next = k_reg + ADDR_W'(1);
                    end
                end
                else
                begin
                    j_next   = j_reg + ADDR_W'(1);
                    idx_next = (idx_reg == nm1_reg) ? '0 : idx_reg + ADDR_W'(1);
                end
            end
            ST_DRAIN:
            begin
                if (s5_done_reg)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            ref_mem[wr_addr] <= ref_sample;
            mic_mem[wr_addr] <= mic_sample;
        end
        rd_ref_reg <= ref_mem[j_reg];
        rd_mic_reg <= mic_mem[idx_reg];
    end

    always_comb
    begin
        acc_wide = WIDE_W'(acc_reg);
        abs_wide = acc_wide[WIDE_W-1] ? -acc_wide : acc_wide;
        mag_sat  = (|abs_wide[WIDE_W-1:MAG_W]) ? '1 : abs_wide[MAG_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_LOAD;
            frame_length_reg <= cxpd_pkg::FRAME_LENGTH_RST;
            threshold_reg    <= '0;
            count_reg        <= '0;
            j_reg            <= '0;
            k_reg            <= '0;
            idx_reg          <= '0;
            nm1_reg          <= '0;
            s1_reg           <= '0;
            s2_reg           <= '0;
            s3_reg           <= '0;
            s4_reg           <= '0;
            s5_done_reg      <= 1'b0;
            acc_reg          <= '0;
            best_lag_reg     <= '0;
            best_mag_reg     <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            idx_reg   <= idx_next;
            nm1_reg   <= nm1_next;

            if (cfg_we)
            begin
                unique case (cxpd_pkg::cfg_reg_t'(cfg_index))
                    cxpd_pkg::CFG_FRAME_LENGTH:
                    begin
                        frame_length_reg <= cfg_data[cxpd_pkg::LEN_W-1:0];
                    end
                    cxpd_pkg::CFG_QUALITY_THRESHOLD:
                    begin
                        threshold_reg <= cfg_data;
                    end
                    default:
                    begin
                        threshold_reg <= threshold_reg;
                    end
                endcase
            end

            s1_reg <= issue_tag;
            s2_reg <= s1_reg;
            if (s2_reg.vld)
            begin
                acc_reg <= (s2_reg.first ? ACC_W'(0) : acc_reg) + ACC_W'(prod_reg);
            end
            s3_reg <= s2_reg;

            s4_reg <= '{vld: s3_reg.vld && s3_reg.last, first: s3_reg.first,
                        last: s3_reg.last, fin: s3_reg.fin, lag: s3_reg.lag};

            if (s4_reg.vld)
            begin
                if ((s4_reg.lag == '0) || (mag_reg > best_mag_reg))
                begin
                    best_lag_reg <= s4_reg.lag;
                    best_mag_reg <= mag_reg;
                end
            end
            s5_done_reg <= s4_reg.vld && s4_reg.fin;

            if (state_reg == ST_DRAIN && s5_done_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= rd_ref_reg * rd_mic_reg;
        if (s3_reg.vld && s3_reg.last)
        begin
            mag_reg <= mag_sat;
        end
        if (state_reg == ST_DRAIN && s5_done_reg)
        begin
            lag_out_reg   <= LAG_W'(best_lag_reg);
            mag_out_reg   <= best_mag_reg;
            acc_out_reg   <= (best_mag_reg >= threshold_reg);
            delay_out_reg <= (best_mag_reg >= threshold_reg) ? LAG_W'(best_lag_reg) : '0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign lag_at_peak    = lag_out_reg;
    assign peak_magnitude = mag_out_reg;
    assign accepted       = acc_out_reg;
    assign delay_samples  = delay_out_reg;

`ifndef SYNTHESIS
    a_result_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DRAIN))
        else $error("Result appeared outside the drain phase.");

    a_no_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CORR) |-> !out_valid_reg)
        else $error("Result pending while a correlation runs.");

    a_delay_matches: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (delay_out_reg == (acc_out_reg ? lag_out_reg : '0)))
        else $error("Delay disagrees with the accepted flag.");
`endif

endmodule
